// ===== hdl/gli_pkg.sv =====
// Shared types, constants and the bin-weight table builder for the loudness integrator.
package gli_pkg;

   localparam int BIN_COUNT_DEF      = 1024;
   localparam int FLOOR_CENTI_LU_DEF = -7000;
   localparam int BIN_COUNT_BITS_DEF = 24;

   localparam int LOG_W     = 128;
   localparam int LOG_RES_W = 23;

   localparam int WEIGHT_W     = 30;
   localparam int WEIGHT_DEPTH = 1000;
   localparam int WIDX_W       = 10;

   localparam logic [14:0] GATE_LEN_RESET = 15'd4800;

   localparam logic signed [25:0] K_CENTI_Q16  = 26'sd19728302;
   localparam logic signed [25:0] K_BIN_Q16    = 26'sd1972830;
   localparam logic signed [24:0] LOG2_1E9_Q16 = 25'sd1959353;
   localparam logic signed [24:0] LOG2_2E40    = 25'sd2621440;
   localparam longint OFFSET_Q32    = 64'sd296782240154;
   localparam longint SILENCE_CENTI = -64'sd14400;
   localparam logic signed [14:0] SILENCE_OUT = -15'sd14400;

   localparam logic [63:0] W_ONE = 64'd1000000000;

   localparam logic [63:0] STEP_TAB [10] = '{
      64'd1000000000, 64'd977237221, 64'd954992586, 64'd933254301, 64'd912010839,
      64'd891250938, 64'd870963590, 64'd851138038, 64'd831763771, 64'd812830516
   };
   localparam logic [63:0] TENTH_TAB [10] = '{
      64'd1000000000, 64'd794328235, 64'd630957344, 64'd501187234, 64'd398107171,
      64'd316227766, 64'd251188643, 64'd199526231, 64'd158489319, 64'd125892541
   };

   typedef logic [WEIGHT_W-1:0] weight_rom_type [WEIGHT_DEPTH];

   typedef enum logic [4:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_ACC,
      ST_LOG_SUM,
      ST_LOG_TALLY,
      ST_LOUD_MUL,
      ST_LOUD_CHK,
      ST_BIN_DIV,
      ST_BIN_RD,
      ST_BIN_WR,
      ST_INT_START,
      ST_WALK,
      ST_LOG_ACC,
      ST_LOG_CNT,
      ST_GATE_MUL,
      ST_GATE,
      ST_OUT_MUL,
      ST_OUT,
      ST_EMIT
   } fsm_state_type;

   typedef enum logic [1:0] {
      LOG_IDLE,
      LOG_NORM,
      LOG_SQ
   } log_state_type;

   // 10^(-d/100) in units of 1e-9, zero from one full decade of ten on
   function automatic weight_rom_type build_weight_rom();
      weight_rom_type rom;
      logic [63:0] x;
      logic [63:0] w;
      for (int q = 0; q < 10; q++) begin
         for (int a = 0; a < 10; a++) begin
            for (int b = 0; b < 10; b++) begin
               x = (TENTH_TAB[a] * STEP_TAB[b] + W_ONE / 2) / W_ONE;
               case (q)
                  0: w = x;
                  1: w = (x + 64'd5) / 64'd10;
                  2: w = (x + 64'd50) / 64'd100;
                  3: w = (x + 64'd500) / 64'd1000;
                  4: w = (x + 64'd5000) / 64'd10000;
                  5: w = (x + 64'd50000) / 64'd100000;
                  6: w = (x + 64'd500000) / 64'd1000000;
                  7: w = (x + 64'd5000000) / 64'd10000000;
                  8: w = (x + 64'd50000000) / 64'd100000000;
                  default: w = (x + 64'd500000000) / 64'd1000000000;
               endcase
               rom[q * 100 + a * 10 + b] = w[WEIGHT_W-1:0];
            end
         end
      end
      return rom;
   endfunction

endpackage

// ===== hdl/gated_loudness_integrator_top.sv =====
// Gated integrated loudness: block accumulation, loudness histogram and gated walk.
//
// After reset the bin memory is cleared, and no item is taken until that is
// done. An item that does not close a gating block passes through the
// accumulate state and back to idle. An item that closes one is followed by up
// to two walks over the bins (one bin memory read a cycle, from the highest
// occupied bin down) and up to six evaluations of the shared log2 unit. A result
// is emitted per closed gating block; items with zero samples are dropped.
module gated_loudness_integrator_top
   import gli_pkg::*;
#(
   parameter int BIN_COUNT      = BIN_COUNT_DEF,
   parameter int FLOOR_CENTI_LU = FLOOR_CENTI_LU_DEF,
   parameter int BIN_COUNT_BITS = BIN_COUNT_BITS_DEF
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // block_energy[47:0], block_samples[60:48], zero
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // integrated_loudness[14:0], block_counted[15]
   input  logic        csr_wr_en,
   input  logic [14:0] csr_wr_data
);

   localparam int IDX_W  = $clog2(BIN_COUNT);
   localparam int CNT_W  = BIN_COUNT_BITS + IDX_W;
   localparam int PROD_W = BIN_COUNT_BITS + WEIGHT_W;
   localparam int ACC_W  = PROD_W + IDX_W;
   localparam int TQ_MAX = 10 * BIN_COUNT - 1;
   localparam int TQ_W   = $clog2(10 * BIN_COUNT);
   localparam int DW     = (IDX_W > WIDX_W) ? IDX_W : WIDX_W;
   localparam logic [IDX_W-1:0] LAST_BIN = IDX_W'(BIN_COUNT - 1);
   localparam longint FLOOR_Q32   = longint'(FLOOR_CENTI_LU) <<< 32;
   localparam longint SILENCE_Q32 = SILENCE_CENTI <<< 32;
   localparam weight_rom_type WEIGHT_ROM = build_weight_rom();

   fsm_state_type state_ff, state_in;

   logic [14:0]               len_ff, len_in;
   logic [63:0]               sum_ff, sum_in;
   logic [15:0]               tally_ff, tally_in;
   logic [60:0]               eprod_ff, eprod_in;
   logic [12:0]               n_ff, n_in;
   logic [LOG_RES_W-1:0]      log_a_ff, log_a_in, log_b_ff, log_b_in;
   logic                      log_busy_ff, log_busy_in;
   logic signed [63:0]        mul_ff, mul_in;
   logic                      counted_ff, counted_in;
   logic [TQ_W-1:0]           tq_ff, tq_in;
   logic [IDX_W-1:0]          bin_ff, bin_in;
   logic [IDX_W-1:0]          top_ff, top_in;
   logic                      top_valid_ff, top_valid_in;
   logic [IDX_W-1:0]          clr_ff, clr_in;
   logic [IDX_W-1:0]          idx_ff, idx_in, lo_ff, lo_in;
   logic                      issue_ff, issue_in, v1_ff, v1_in, v2_ff, v2_in;
   logic                      pass_ff, pass_in;
   logic [PROD_W-1:0]         wprod_ff, wprod_in;
   logic [BIN_COUNT_BITS-1:0] wcnt_ff, wcnt_in;
   logic [ACC_W-1:0]          acc_ff, acc_in;
   logic [CNT_W-1:0]          cnt_ff, cnt_in;
   logic signed [14:0]        res_ff, res_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [15:0]               rsp_data_ff, rsp_data_in;

   logic [BIN_COUNT_BITS-1:0] bins_mem [BIN_COUNT];
   logic [BIN_COUNT_BITS-1:0] bin_rd_ff;
   logic [WEIGHT_W-1:0]       w_rd_ff;
   logic                      mem_we;
   logic [IDX_W-1:0]          mem_wa, mem_ra;
   logic [BIN_COUNT_BITS-1:0] mem_wd;
   logic [DW-1:0]             rom_d;

   logic                      log_start, log_done;
   logic [LOG_W-1:0]          log_x;
   logic [LOG_RES_W-1:0]      log_res;

   logic [15:0]               eff_len;
   logic signed [24:0]        dofs, dlog;
   logic signed [25:0]        kmul;
   logic signed [50:0]        mprod;
   logic signed [63:0]        lq, flr_gap, gq, vq;
   logic [31:0]               t32;
   logic [TQ_W+15:0]          div_prod;
   logic [IDX_W-1:0]          start_bin;

   gli_log2 u_log2 (
      .clock  (clock),
      .reset  (reset),
      .start  (log_start),
      .x      (log_x),
      .done   (log_done),
      .result (log_res)
   );

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   assign eff_len  = (len_ff == '0) ? 16'd1 : {1'b0, len_ff};
   assign dofs     = (state_ff == ST_LOUD_MUL) ? LOG2_2E40 : LOG2_1E9_Q16;
   assign kmul     = (state_ff == ST_GATE_MUL) ? K_BIN_Q16 : K_CENTI_Q16;
   assign dlog     = $signed({2'b00, log_a_ff}) - $signed({2'b00, log_b_ff}) - dofs;
   assign mprod    = dlog * kmul;
   assign div_prod = tq_ff * 16'd52429;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         bins_mem[mem_wa] <= mem_wd;
      end
      bin_rd_ff <= bins_mem[mem_ra];
      w_rd_ff   <= (rom_d < DW'(WEIGHT_DEPTH)) ? WEIGHT_ROM[rom_d[WIDX_W-1:0]] : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         len_ff       <= GATE_LEN_RESET;
         sum_ff       <= '0;
         tally_ff     <= '0;
         log_busy_ff  <= 1'b0;
         top_valid_ff <= 1'b0;
         clr_ff       <= '0;
         issue_ff     <= 1'b0;
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         len_ff       <= len_in;
         sum_ff       <= sum_in;
         tally_ff     <= tally_in;
         log_busy_ff  <= log_busy_in;
         top_valid_ff <= top_valid_in;
         clr_ff       <= clr_in;
         issue_ff     <= issue_in;
         v1_ff        <= v1_in;
         v2_ff        <= v2_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      eprod_ff    <= eprod_in;
      n_ff        <= n_in;
      log_a_ff    <= log_a_in;
      log_b_ff    <= log_b_in;
      mul_ff      <= mul_in;
      counted_ff  <= counted_in;
      tq_ff       <= tq_in;
      bin_ff      <= bin_in;
      top_ff      <= top_in;
      idx_ff      <= idx_in;
      lo_ff       <= lo_in;
      pass_ff     <= pass_in;
      wprod_ff    <= wprod_in;
      wcnt_ff     <= wcnt_in;
      acc_ff      <= acc_in;
      cnt_ff      <= cnt_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_comb begin
      state_in     = state_ff;
      len_in       = csr_wr_en ? csr_wr_data : len_ff;
      sum_in       = sum_ff;
      tally_in     = tally_ff;
      eprod_in     = eprod_ff;
      n_in         = n_ff;
      log_a_in     = log_a_ff;
      log_b_in     = log_b_ff;
      log_busy_in  = log_busy_ff;
      mul_in       = mul_ff;
      counted_in   = counted_ff;
      tq_in        = tq_ff;
      bin_in       = bin_ff;
      top_in       = top_ff;
      top_valid_in = top_valid_ff;
      clr_in       = clr_ff;
      idx_in       = idx_ff;
      lo_in        = lo_ff;
      issue_in     = issue_ff;
      v1_in        = (state_ff == ST_WALK) && issue_ff;
      v2_in        = v1_ff;
      pass_in      = pass_ff;
      wprod_in     = bin_rd_ff * w_rd_ff;
      wcnt_in      = bin_rd_ff;
      acc_in       = acc_ff;
      cnt_in       = cnt_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      mem_we       = 1'b0;
      mem_wa       = bin_ff;
      mem_wd       = '0;
      mem_ra       = (state_ff == ST_BIN_RD) ? bin_ff : idx_ff;
      rom_d        = DW'(top_ff - idx_ff);
      log_start    = 1'b0;
      log_x        = '0;
      lq           = '0;
      flr_gap      = '0;
      gq           = '0;
      vq           = '0;
      t32          = '0;
      start_bin    = '0;

      case (state_ff)
         ST_CLEAR: begin
            mem_we = 1'b1;
            mem_wa = clr_ff;
            clr_in = clr_ff + 1'b1;
            if (clr_ff == LAST_BIN) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_tvalid) begin
               eprod_in = req_tdata[47:0] * req_tdata[60:48];
               n_in     = req_tdata[60:48];
               if (req_tdata[60:48] != '0) begin
                  state_in = ST_ACC;
               end
            end
         end
         ST_ACC: begin
            sum_in   = sum_ff + 64'(eprod_ff);
            tally_in = tally_ff + 16'(n_ff);
            state_in = (tally_in >= eff_len) ? ST_LOG_SUM : ST_IDLE;
         end
         ST_LOG_SUM, ST_LOG_TALLY, ST_LOG_ACC, ST_LOG_CNT: begin
            case (state_ff)
               ST_LOG_SUM:   log_x = LOG_W'(sum_ff);
               ST_LOG_TALLY: log_x = LOG_W'(tally_ff);
               ST_LOG_ACC:   log_x = LOG_W'(acc_ff);
               default:      log_x = LOG_W'(cnt_ff);
            endcase
            if (!log_busy_ff) begin
               log_start   = 1'b1;
               log_busy_in = 1'b1;
            end
            if (log_done) begin
               log_busy_in = 1'b0;
               case (state_ff)
                  ST_LOG_SUM: begin
                     log_a_in = log_res;
                     state_in = ST_LOG_TALLY;
                  end
                  ST_LOG_TALLY: begin
                     log_b_in = log_res;
                     state_in = ST_LOUD_MUL;
                  end
                  ST_LOG_ACC: begin
                     log_a_in = log_res;
                     state_in = ST_LOG_CNT;
                  end
                  default: begin
                     log_b_in = log_res;
                     state_in = pass_ff ? ST_OUT_MUL : ST_GATE_MUL;
                  end
               endcase
            end
         end
         ST_LOUD_MUL, ST_GATE_MUL, ST_OUT_MUL: begin
            mul_in = {{13{mprod[50]}}, mprod};
            case (state_ff)
               ST_LOUD_MUL: state_in = ST_LOUD_CHK;
               ST_GATE_MUL: state_in = ST_GATE;
               default:     state_in = ST_OUT;
            endcase
         end
         ST_LOUD_CHK: begin
            lq         = (sum_ff == '0) ? SILENCE_Q32 : (mul_ff - OFFSET_Q32);
            flr_gap    = lq - FLOOR_Q32 + (64'sd5 <<< 32);
            t32        = flr_gap[63:32];
            counted_in = (lq >= FLOOR_Q32);
            tq_in      = (t32 > 32'(TQ_MAX)) ? TQ_W'(TQ_MAX) : t32[TQ_W-1:0];
            sum_in     = '0;
            tally_in   = '0;
            state_in   = counted_in ? ST_BIN_DIV : ST_INT_START;
         end
         ST_BIN_DIV: begin
            bin_in   = div_prod[19 +: IDX_W];
            state_in = ST_BIN_RD;
         end
         ST_BIN_RD: begin
            state_in = ST_BIN_WR;
         end
         ST_BIN_WR: begin
            mem_we = 1'b1;
            mem_wd = (&bin_rd_ff) ? bin_rd_ff : bin_rd_ff + 1'b1;
            if (!top_valid_ff || (bin_ff > top_ff)) begin
               top_in = bin_ff;
            end
            top_valid_in = 1'b1;
            state_in     = ST_INT_START;
         end
         ST_INT_START: begin
            if (!top_valid_ff) begin
               res_in   = SILENCE_OUT;
               state_in = ST_EMIT;
            end else begin
               pass_in  = 1'b0;
               idx_in   = top_ff;
               lo_in    = '0;
               issue_in = 1'b1;
               acc_in   = '0;
               cnt_in   = '0;
               state_in = ST_WALK;
            end
         end
         ST_WALK: begin
            if (issue_ff) begin
               if (idx_ff == lo_ff) begin
                  issue_in = 1'b0;
               end else begin
                  idx_in = idx_ff - 1'b1;
               end
            end
            if (v2_ff) begin
               acc_in = acc_ff + ACC_W'(wprod_ff);
               cnt_in = cnt_ff + CNT_W'(wcnt_ff);
            end
            if (!issue_ff && !v1_ff && !v2_ff) begin
               if (pass_ff && (cnt_ff == '0)) begin
                  res_in   = SILENCE_OUT;
                  state_in = ST_EMIT;
               end else begin
                  state_in = ST_LOG_ACC;
               end
            end
         end
         ST_GATE: begin
            gq = ((longint'(top_ff) - 64'sd100) <<< 32) + mul_ff + 64'sd4294967295;
            gq = gq >>> 32;
            if (gq < 0) begin
               start_bin = '0;
            end else if (gq > longint'(BIN_COUNT - 1)) begin
               start_bin = LAST_BIN;
            end else begin
               start_bin = gq[IDX_W-1:0];
            end
            if (start_bin > top_ff) begin
               res_in   = SILENCE_OUT;
               state_in = ST_EMIT;
            end else begin
               pass_in  = 1'b1;
               idx_in   = top_ff;
               lo_in    = start_bin;
               issue_in = 1'b1;
               acc_in   = '0;
               cnt_in   = '0;
               state_in = ST_WALK;
            end
         end
         ST_OUT: begin
            vq = ((longint'(FLOOR_CENTI_LU) + 64'sd10 * longint'(top_ff)) <<< 32)
                 + mul_ff + 64'sd2147483648;
            vq = vq >>> 32;
            if (vq < -64'sd16384) begin
               res_in = 15'h4000;
            end else if (vq > 64'sd16383) begin
               res_in = 15'sd16383;
            end else begin
               res_in = vq[14:0];
            end
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {counted_ff, res_ff};
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

// ===== hdl/gli_log2.sv =====
// Iterative log2 unit: normalize, then 16 mantissa squarings, Q16 result.
module gli_log2
   import gli_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [LOG_W-1:0]     x,
   output logic                 done,
   output logic [LOG_RES_W-1:0] result
);

   log_state_type        state_ff, state_in;
   logic [LOG_W-1:0]     xn_ff, xn_in;
   logic [6:0]           e_ff, e_in;
   logic [31:0]          m_ff, m_in;
   logic [15:0]          frac_ff, frac_in;
   logic [3:0]           i_ff, i_in;
   logic                 done_ff, done_in;
   logic [LOG_RES_W-1:0] res_ff, res_in;
   logic [63:0]          sq;

   assign sq     = m_ff * m_ff;
   assign done   = done_ff;
   assign result = res_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= LOG_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      xn_ff   <= xn_in;
      e_ff    <= e_in;
      m_ff    <= m_in;
      frac_ff <= frac_in;
      i_ff    <= i_in;
      res_ff  <= res_in;
   end

   always_comb begin
      state_in = state_ff;
      xn_in    = xn_ff;
      e_in     = e_ff;
      m_in     = m_ff;
      frac_in  = frac_ff;
      i_in     = i_ff;
      done_in  = 1'b0;
      res_in   = res_ff;
      case (state_ff)
         LOG_IDLE: begin
            if (start) begin
               if (x == '0) begin
                  res_in  = '0;
                  done_in = 1'b1;
               end else begin
                  xn_in    = x;
                  e_in     = 7'd127;
                  state_in = LOG_NORM;
               end
            end
         end
         LOG_NORM: begin
            if (xn_ff[LOG_W-1 -: 16] == 16'd0) begin
               xn_in = xn_ff << 16;
               e_in  = e_ff - 7'd16;
            end else if (!xn_ff[LOG_W-1]) begin
               xn_in = xn_ff << 1;
               e_in  = e_ff - 7'd1;
            end else begin
               m_in     = xn_ff[LOG_W-1 -: 32];
               frac_in  = '0;
               i_in     = '0;
               state_in = LOG_SQ;
            end
         end
         LOG_SQ: begin
            frac_in = {frac_ff[14:0], sq[63]};
            m_in    = sq[63] ? sq[63:32] : sq[62:31];
            i_in    = i_ff + 4'd1;
            if (i_ff == 4'd15) begin
               res_in   = {e_ff, frac_in};
               done_in  = 1'b1;
               state_in = LOG_IDLE;
            end
         end
         default: state_in = LOG_IDLE;
      endcase
   end

endmodule
